// ===== hw/rtl/multi_channel_software_timer_table_core_macros.svh =====
// Assertion macros for the software timer table core.
// Included by the top level; relies on clk and rst in the including scope.
`ifndef MULTI_CHANNEL_SOFTWARE_TIMER_TABLE_CORE_MACROS_SVH
`define MULTI_CHANNEL_SOFTWARE_TIMER_TABLE_CORE_MACROS_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define MCST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mcst assertion failed");
// Check a property on every clock edge, reset included.
`define MCST_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mcst assertion failed");
`else
`define MCST_ASSERT(lbl, prop)
`define MCST_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hw/rtl/mcst_pkg.sv =====
// Shared types and constants for the software timer table core.
// No dependencies; imported by the interfaces, the top level and the testbench.
`default_nettype none

package mcst_pkg;

  localparam int DelayW  = 16;
  localparam int IdW     = 8;
  localparam int CountW  = 32;
  localparam int ResW    = 16;
  localparam int StatusW = 2;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_START    = 2'd1,
    OP_STOP     = 2'd2,
    OP_DISPATCH = 2'd3
  } opcode_t;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd1;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd2;

  // One timer table entry as stored in memory.
  typedef struct packed {
    logic [DelayW-1:0] delay;
    logic              rpt;
    logic [IdW-1:0]    id;
    logic [CountW-1:0] count;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

`default_nettype wire

// ===== hw/rtl/mcst_ifs.sv =====
// Handshake channel interfaces of the software timer table core.
// Depends on mcst_pkg for field widths.
`default_nettype none

interface mcst_cmd_if import mcst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [DelayW-1:0] delay;
  logic              repeat_req;
  logic [IdW-1:0]    task_id;

  modport source (output valid, opcode, delay, repeat_req, task_id, input ready);
  modport sink   (input valid, opcode, delay, repeat_req, task_id, output ready);
endinterface

interface mcst_rsp_if import mcst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic               fired;
  logic [IdW-1:0]     fired_id;
  logic               last;

  modport source (output valid, status, fired, fired_id, last, input ready);
  modport sink   (input valid, status, fired, fired_id, last, output ready);
endinterface

interface mcst_cfg_if import mcst_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ResW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mcst_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module mcst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/multi_channel_software_timer_table_core.sv =====
// Top level of the software timer table core: control sequencer and table.
// Depends on mcst_pkg, mcst_ifs, mcst_ram and the assertion macro header.
`default_nettype none

`include "multi_channel_software_timer_table_core_macros.svh"

// A table of up to MAX_TASKS software timers held in one memory, one entry
// per word (delay, periodic flag, task id, 32-bit elapsed count). Each
// command transfer on cmd carries an opcode: tick advances the prescaler
// and, when it reaches the resolution register, bumps every live count
// (saturating); start appends an entry with a cleared count (status full
// when the table is full); stop removes the first entry with that id by
// moving the last entry into its slot (status not found otherwise);
// dispatch, when a tick is pending, walks the table in order and returns
// one rsp transfer per expired entry, clearing its count and removing it
// if it is one-shot. Every command ends with exactly one rsp transfer that
// has last set. Commands are taken one at a time, since every table access
// goes through the single registered read port of the memory: start writes
// its entry straight from idle; a tick reads and writes back each live
// entry when the prescaler reaches resolution; stop reads entries until
// one matches, then moves the last entry in when the match is not in the
// last slot; dispatch reads each entry in order (a slot scanned again
// after a removal is read again) and moves the last entry in for each
// one-shot removal that is not in the last slot. A result waiting on a
// stalled rsp sink holds the sequencer; the next command is taken as soon
// as the final result sits in the output register. resolution may be
// written at any time over cfg, which is always ready.
module multi_channel_software_timer_table_core
  import mcst_pkg::*;
#(
  parameter int MAX_TASKS = 8
) (
  input wire logic clk,
  input wire logic rst,
  mcst_cfg_if.sink   cfg,
  mcst_cmd_if.sink   cmd,
  mcst_rsp_if.source rsp
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_TICK_RD = 10'b00_0000_0010,
    S_TICK_WR = 10'b00_0000_0100,
    S_STOP_RD = 10'b00_0000_1000,
    S_STOP_EV = 10'b00_0001_0000,
    S_DISP_RD = 10'b00_0010_0000,
    S_DISP_EV = 10'b00_0100_0000,
    S_TAIL_RD = 10'b00_1000_0000,
    S_TAIL_WR = 10'b01_0000_0000,
    S_FIN     = 10'b10_0000_0000
  } state_t;

  state_t state;

  // Control and sequencing registers.
  logic [CW-1:0]      active;
  logic [CW-1:0]      idx;
  logic [IW-1:0]      pos;
  logic [ResW-1:0]    prescale;
  logic [ResW-1:0]    resolution;
  logic               tick_pending;
  logic               from_stop;
  logic [StatusW-1:0] fin_status;
  logic [IdW-1:0]     stop_id;
  // Fired result held back until we know whether it is the final one.
  logic               held_valid;
  logic [IdW-1:0]     held_id;

  // Output register.
  logic               ovalid;
  logic [StatusW-1:0] ostatus;
  logic               ofired;
  logic [IdW-1:0]     ofired_id;
  logic               olast;

  // Memory port signals.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [EntryW-1:0] ram_rdata;
  entry_t        rd_ent;

  logic               cmd_fire;
  logic               can_push;
  logic               push;
  logic [StatusW-1:0] push_status;
  logic               push_fired;
  logic [IdW-1:0]     push_id;
  logic               push_last;

  logic [CW-1:0]     active_m1;
  logic [CW-1:0]     idx_inc;
  logic              last_slot;
  logic              full;
  logic [ResW-1:0]   presc_inc;
  logic              expired;
  logic              stall;
  logic [CountW-1:0] count_inc;
  opcode_t           op;

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign op        = opcode_t'(cmd.opcode);

  assign rsp.valid    = ovalid;
  assign rsp.status   = ostatus;
  assign rsp.fired    = ofired;
  assign rsp.fired_id = ofired_id;
  assign rsp.last     = olast;

  assign rd_ent    = entry_t'(ram_rdata);
  assign active_m1 = active - CW'(1);
  assign idx_inc   = idx + CW'(1);
  assign last_slot = (idx_inc >= active);
  assign full      = (active == CW'(MAX_TASKS));
  assign presc_inc = prescale + ResW'(1);
  assign expired   = (rd_ent.count >= {{(CountW-DelayW){1'b0}}, rd_ent.delay});
  assign count_inc = (rd_ent.count == '1) ? rd_ent.count : rd_ent.count + CountW'(1);
  assign can_push  = !ovalid || rsp.ready;
  // A new expiry must first push out the one already held.
  assign stall     = expired && held_valid && !can_push;

  mcst_ram #(
    .WIDTH (EntryW),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read address: the scanned slot, or the last live slot for a move.
  always_comb begin
    case (state)
      S_TAIL_RD: ram_raddr = active_m1[IW-1:0];
      default:   ram_raddr = idx[IW-1:0];
    endcase
  end

  // Write port: append, count update, count clear, or move of last entry.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[IW-1:0];
    ram_wdata = rd_ent;
    case (state)
      S_IDLE: begin
        if (cmd_fire && op == OP_START && !full) begin
          ram_we          = 1'b1;
          ram_waddr       = active[IW-1:0];
          ram_wdata.delay = cmd.delay;
          ram_wdata.rpt   = cmd.repeat_req;
          ram_wdata.id    = cmd.task_id;
          ram_wdata.count = '0;
        end
      end
      S_TICK_WR: begin
        ram_we          = 1'b1;
        ram_wdata.count = count_inc;
      end
      S_DISP_EV: begin
        if (expired && !stall && rd_ent.rpt) begin
          ram_we          = 1'b1;
          ram_wdata.count = '0;
        end
      end
      S_TAIL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // Result push into the output register.
  always_comb begin
    push        = 1'b0;
    push_status = ST_OK;
    push_fired  = held_valid;
    push_id     = held_id;
    push_last   = 1'b1;
    case (state)
      S_DISP_EV: begin
        if (expired && held_valid && can_push) begin
          push      = 1'b1;
          push_last = 1'b0;
        end
      end
      S_FIN: begin
        push        = can_push;
        push_status = fin_status;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active       <= '0;
      prescale     <= '0;
      tick_pending <= 1'b0;
      resolution   <= ResW'(1);
      ovalid       <= 1'b0;
      held_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        resolution <= cfg.data;
      end

      // Output register: load on push, drop once the sink takes it.
      if (push) begin
        ovalid    <= 1'b1;
        ostatus   <= push_status;
        ofired    <= push_fired;
        ofired_id <= push_id;
        olast     <= push_last;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            held_valid <= 1'b0;
            held_id    <= '0;
            fin_status <= ST_OK;
            idx        <= '0;
            stop_id    <= cmd.task_id;
            case (op)
              OP_TICK: begin
                tick_pending <= 1'b1;
                if (presc_inc == resolution) begin
                  prescale <= '0;
                  state    <= (active != '0) ? S_TICK_RD : S_FIN;
                end else begin
                  prescale <= presc_inc;
                  state    <= S_FIN;
                end
              end
              OP_START: begin
                if (full) begin
                  fin_status <= ST_FULL;
                end else begin
                  active <= active + CW'(1);
                end
                state <= S_FIN;
              end
              OP_STOP: begin
                if (active == '0) begin
                  fin_status <= ST_NOT_FOUND;
                  state      <= S_FIN;
                end else begin
                  state <= S_STOP_RD;
                end
              end
              default: begin
                // Dispatch: scan only when a tick is pending.
                if (tick_pending) begin
                  tick_pending <= 1'b0;
                  state        <= (active != '0) ? S_DISP_RD : S_FIN;
                end else begin
                  state <= S_FIN;
                end
              end
            endcase
          end
        end

        S_TICK_RD: state <= S_TICK_WR;

        S_TICK_WR: begin
          idx   <= idx_inc;
          state <= last_slot ? S_FIN : S_TICK_RD;
        end

        S_STOP_RD: state <= S_STOP_EV;

        S_STOP_EV: begin
          if (rd_ent.id == stop_id) begin
            if (last_slot) begin
              // Match in the last slot: just shrink.
              active <= active_m1;
              state  <= S_FIN;
            end else begin
              pos       <= idx[IW-1:0];
              from_stop <= 1'b1;
              state     <= S_TAIL_RD;
            end
          end else if (last_slot) begin
            fin_status <= ST_NOT_FOUND;
            state      <= S_FIN;
          end else begin
            idx   <= idx_inc;
            state <= S_STOP_RD;
          end
        end

        S_DISP_RD: state <= S_DISP_EV;

        S_DISP_EV: begin
          if (expired) begin
            if (!stall) begin
              held_valid <= 1'b1;
              held_id    <= rd_ent.id;
              if (rd_ent.rpt) begin
                if (last_slot) begin
                  state <= S_FIN;
                end else begin
                  idx   <= idx_inc;
                  state <= S_DISP_RD;
                end
              end else if (last_slot) begin
                active <= active_m1;
                state  <= S_FIN;
              end else begin
                // One-shot: move the last entry in and scan this slot again.
                pos       <= idx[IW-1:0];
                from_stop <= 1'b0;
                state     <= S_TAIL_RD;
              end
            end
          end else if (last_slot) begin
            state <= S_FIN;
          end else begin
            idx   <= idx_inc;
            state <= S_DISP_RD;
          end
        end

        S_TAIL_RD: state <= S_TAIL_WR;

        S_TAIL_WR: begin
          active <= active_m1;
          state  <= from_stop ? S_FIN : S_DISP_RD;
        end

        S_FIN: begin
          if (can_push) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // The table never holds more than MAX_TASKS live entries.
  `MCST_ASSERT_ALWAYS(a_active_bound, rst || (active <= CW'(MAX_TASKS)))
  // Results only leave from the final step or from a dispatch scan.
  `MCST_ASSERT(a_push_src, push |-> (state == S_FIN || state == S_DISP_EV))
  // A mid-scan result is never marked final.
  `MCST_ASSERT(a_mid_not_last, (push && state == S_DISP_EV) |-> !push_last)
  // Dispatch always consumes the pending tick.
  `MCST_ASSERT(a_disp_clears, (cmd_fire && op == OP_DISPATCH) |=> !tick_pending)
  // Outside an append, writes only touch live slots.
  `MCST_ASSERT(a_wr_live, (ram_we && state != S_IDLE) |-> (CW'(ram_waddr) < active))

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for multi_channel_software_timer_table_core.
// Depends on mcst_pkg and the channel interfaces in mcst_ifs from the RTL.
`timescale 1ns / 1ps

module tb;
  import mcst_pkg::*;

  localparam int MaxTasks   = 8;
  localparam int CycleLimit = 400000;

  // One command as driven on cmd, one result as seen on rsp.
  typedef struct packed {
    opcode_t           op;
    logic [DelayW-1:0] delay;
    logic              rpt;
    logic [IdW-1:0]    id;
  } cmd_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               fired;
    logic [IdW-1:0]     fired_id;
    logic               last;
  } rsp_t;

  logic clk;
  logic rst;

  mcst_cfg_if cfg_ch ();
  mcst_cmd_if cmd_ch ();
  mcst_rsp_if rsp_ch ();

  multi_channel_software_timer_table_core #(
    .MAX_TASKS(MaxTasks)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  // Predicted image of the timer table, prescaler and resolution register.
  logic [ResW-1:0]   res_reg;
  logic [DelayW-1:0] tbl_delay [MaxTasks];
  logic              tbl_rpt   [MaxTasks];
  logic [IdW-1:0]    tbl_id    [MaxTasks];
  logic [CountW-1:0] tbl_count [MaxTasks];
  int                tbl_used;
  logic [ResW-1:0]   pre_cnt;
  logic              tick_flag;

  // Commands waiting to be driven, and results owed by the block in order.
  cmd_t cmd_backlog [$];
  rsp_t rsp_due     [$];

  bit cmd_taken;
  bit no_idle;
  int gap_left;
  int stall_left;
  int cycles;
  int fail_cnt;
  int n_cmds;
  int n_results;
  int n_fired;
  int n_full;
  int n_missing;
  int n_cfg;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Gap length for either side: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // Move the last live entry into slot pos and shrink the table.
  function automatic void drop_slot(int pos);
    int tail;
    tail = tbl_used - 1;
    tbl_delay[pos] = tbl_delay[tail];
    tbl_rpt[pos]   = tbl_rpt[tail];
    tbl_id[pos]    = tbl_id[tail];
    tbl_count[pos] = tbl_count[tail];
    tbl_used       = tail;
  endfunction

  // Apply one accepted command to the table image and queue the results it owes.
  function automatic void advance_timer_table(cmd_t c);
    rsp_t r;
    rsp_t h;
    rsp_t hits [$];
    int   i;
    int   k;
    bit   found;
    r      = '0;
    r.last = 1'b1;
    case (c.op)
      OP_TICK: begin
        tick_flag = 1'b1;
        pre_cnt   = pre_cnt + 1'b1;
        // The prescaler wraps at 16 bits; counts saturate at all ones.
        if (pre_cnt == res_reg) begin
          pre_cnt = '0;
          for (i = 0; i < tbl_used; i++)
            if (tbl_count[i] != '1) tbl_count[i] = tbl_count[i] + 1'b1;
        end
        rsp_due.push_back(r);
      end
      OP_START: begin
        if (tbl_used < MaxTasks) begin
          tbl_delay[tbl_used] = c.delay;
          tbl_rpt[tbl_used]   = c.rpt;
          tbl_id[tbl_used]    = c.id;
          tbl_count[tbl_used] = '0;
          tbl_used++;
        end else begin
          r.status = ST_FULL;
        end
        rsp_due.push_back(r);
      end
      OP_STOP: begin
        found = 1'b0;
        for (i = 0; i < tbl_used && !found; i++) begin
          if (tbl_id[i] == c.id) begin
            drop_slot(i);
            found = 1'b1;
          end
        end
        if (!found) r.status = ST_NOT_FOUND;
        rsp_due.push_back(r);
      end
      OP_DISPATCH: begin
        if (tick_flag) begin
          i = 0;
          while (i < tbl_used) begin
            if (tbl_count[i] >= CountW'(tbl_delay[i])) begin
              tbl_count[i] = '0;
              h          = '0;
              h.fired    = 1'b1;
              h.fired_id = tbl_id[i];
              hits.push_back(h);
              // A one-shot entry leaves; rescan the slot that the tail moved into.
              if (!tbl_rpt[i]) drop_slot(i);
              else i++;
            end else begin
              i++;
            end
          end
          tick_flag = 1'b0;
        end
        if (hits.size() == 0) begin
          rsp_due.push_back(r);
        end else begin
          for (k = 0; k < hits.size(); k++) begin
            h      = hits[k];
            h.last = (k == hits.size() - 1);
            rsp_due.push_back(h);
          end
        end
      end
    endcase
  endfunction

  function automatic cmd_t make_cmd(opcode_t op, logic [DelayW-1:0] delay, logic rpt,
                                    logic [IdW-1:0] id);
    cmd_t c;
    c.op    = op;
    c.delay = delay;
    c.rpt   = rpt;
    c.id    = id;
    return c;
  endfunction

  // Random command: ids mostly from a small pool so stops hit and ids repeat,
  // delays mostly short so entries expire within a phase.
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   r;
    r = $urandom_range(0, 99);
    if (r < 35)      c.op = OP_TICK;
    else if (r < 60) c.op = OP_START;
    else if (r < 75) c.op = OP_STOP;
    else             c.op = OP_DISPATCH;
    r = $urandom_range(0, 99);
    if (r < 80)      c.delay = DelayW'($urandom_range(0, 6));
    else if (r < 90) c.delay = DelayW'($urandom_range(7, 40));
    else             c.delay = DelayW'($urandom_range(0, 65535));
    c.rpt = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) != 0) c.id = IdW'($urandom_range(0, 5));
    else                           c.id = IdW'($urandom_range(0, 255));
    return c;
  endfunction

  // Sample the cmd handshake at the rising edge; predict each transfer.
  always @(posedge clk) begin : cmd_sampler
    cmd_taken <= !rst && cmd_ch.valid && cmd_ch.ready;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      advance_timer_table(make_cmd(opcode_t'(cmd_ch.opcode), cmd_ch.delay,
                                   cmd_ch.repeat_req, cmd_ch.task_id));
      n_cmds++;
    end
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, rsp_due.size());
      $display("tb failed");
      $finish;
    end
  end

  // Drive cmd at the falling edge: hold an item until taken, then idle a
  // random gap before the next one from the backlog.
  always @(negedge clk) begin : cmd_driver
    cmd_t nxt;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (cmd_ch.valid && !cmd_taken) begin
      // hold the current item
    end else begin
      if (cmd_taken) gap_left = pick_gap();
      if (gap_left != 0) begin
        cmd_ch.valid <= 1'b0;
        gap_left--;
      end else if (cmd_backlog.size() != 0) begin
        nxt = cmd_backlog.pop_front();
        cmd_ch.valid      <= 1'b1;
        cmd_ch.opcode     <= nxt.op;
        cmd_ch.delay      <= nxt.delay;
        cmd_ch.repeat_req <= nxt.rpt;
        cmd_ch.task_id    <= nxt.id;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random, also at the falling edge.
  always @(negedge clk) begin : rsp_stall
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_ch.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Compare each rsp transfer field by field with the oldest owed result.
  always @(posedge clk) begin : rsp_monitor
    rsp_t got;
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status   = rsp_ch.status;
      got.fired    = rsp_ch.fired;
      got.fired_id = rsp_ch.fired_id;
      got.last     = rsp_ch.last;
      n_results++;
      if (got.fired) n_fired++;
      if (got.status == ST_FULL) n_full++;
      if (got.status == ST_NOT_FOUND) n_missing++;
      if (rsp_due.size() == 0) begin
        $error("rsp transfer with nothing owed: status %0d fired %0d fired_id %0d last %0d",
               got.status, got.fired, got.fired_id, got.last);
        fail_cnt++;
      end else begin
        want = rsp_due.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_cnt++;
        end
        if (got.fired !== want.fired) begin
          $error("fired: expected %0d, got %0d", want.fired, got.fired);
          fail_cnt++;
        end
        if (got.fired_id !== want.fired_id) begin
          $error("fired_id: expected 0x%02h, got 0x%02h", want.fired_id, got.fired_id);
          fail_cnt++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          fail_cnt++;
        end
      end
    end
  end

  // Wait until the backlog is sent and every owed result has arrived, then settle.
  task automatic wait_idle(int settle);
    while (cmd_backlog.size() != 0 || cmd_ch.valid || rsp_due.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_resolution(logic [ResW-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    res_reg = value;
    n_cfg++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // One random phase at a given resolution.
  task automatic run_phase(logic [ResW-1:0] res, int n_items, bit calm);
    int k;
    // Before lowering the period, tick the prescaler round to zero so the
    // new setting takes effect at once instead of after a 16-bit wrap.
    if (res != 0 && res < res_reg && res_reg != 0 && pre_cnt != 0 && pre_cnt < res_reg) begin
      for (k = 0; k < int'(res_reg - pre_cnt); k++)
        cmd_backlog.push_back(make_cmd(OP_TICK, '0, 1'b0, '0));
      wait_idle(40);
    end
    write_resolution(res);
    no_idle = calm;
    for (k = 0; k < n_items; k++) cmd_backlog.push_back(rand_cmd());
    wait_idle(40);
  endtask

  initial begin : stimulus
    int i;
    rst               = 1'b1;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.opcode     = OP_TICK;
    cmd_ch.delay      = '0;
    cmd_ch.repeat_req = 1'b0;
    cmd_ch.task_id    = '0;
    rsp_ch.ready      = 1'b0;
    res_reg   = 16'd1;
    tbl_used  = 0;
    pre_cnt   = '0;
    tick_flag = 1'b0;
    for (i = 0; i < MaxTasks; i++) tbl_count[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset resolution of one.
    // Dispatch and stop on an empty table, then a tick with nothing live.
    cmd_backlog.push_back(make_cmd(OP_DISPATCH, '0, 1'b0, '0));
    cmd_backlog.push_back(make_cmd(OP_STOP, '0, 1'b0, 8'h12));
    cmd_backlog.push_back(make_cmd(OP_TICK, '0, 1'b0, '0));
    cmd_backlog.push_back(make_cmd(OP_DISPATCH, '0, 1'b0, '0));
    // Fill the table: field extremes, zero delay, a duplicate id.
    cmd_backlog.push_back(make_cmd(OP_START, 16'd0, 1'b1, 8'hFF));
    cmd_backlog.push_back(make_cmd(OP_START, 16'hFFFF, 1'b0, 8'h00));
    cmd_backlog.push_back(make_cmd(OP_START, 16'd1, 1'b0, 8'hAA));
    cmd_backlog.push_back(make_cmd(OP_START, 16'd2, 1'b1, 8'hAA));
    cmd_backlog.push_back(make_cmd(OP_START, 16'd0, 1'b0, 8'h55));
    cmd_backlog.push_back(make_cmd(OP_START, 16'd3, 1'b1, 8'h01));
    cmd_backlog.push_back(make_cmd(OP_START, 16'd1, 1'b0, 8'h80));
    cmd_backlog.push_back(make_cmd(OP_START, 16'd0, 1'b1, 8'h7F));
    // Start into a full table.
    cmd_backlog.push_back(make_cmd(OP_START, 16'd5, 1'b1, 8'h42));
    // Expire several at once, one-shots removed with the slot rescanned.
    cmd_backlog.push_back(make_cmd(OP_TICK, '0, 1'b0, '0));
    cmd_backlog.push_back(make_cmd(OP_DISPATCH, '0, 1'b0, '0));
    cmd_backlog.push_back(make_cmd(OP_TICK, '0, 1'b0, '0));
    cmd_backlog.push_back(make_cmd(OP_TICK, '0, 1'b0, '0));
    cmd_backlog.push_back(make_cmd(OP_DISPATCH, '0, 1'b0, '0));
    // Stop the first of two equal ids, then an id that is absent.
    cmd_backlog.push_back(make_cmd(OP_START, 16'd4, 1'b1, 8'hFF));
    cmd_backlog.push_back(make_cmd(OP_STOP, '0, 1'b0, 8'hFF));
    cmd_backlog.push_back(make_cmd(OP_STOP, '0, 1'b0, 8'h33));
    // Dispatch with no tick pending, then with one.
    cmd_backlog.push_back(make_cmd(OP_DISPATCH, '0, 1'b0, '0));
    cmd_backlog.push_back(make_cmd(OP_TICK, '0, 1'b0, '0));
    cmd_backlog.push_back(make_cmd(OP_DISPATCH, '0, 1'b0, '0));
    wait_idle(40);

    // Random phases; the last two put the prescaler at its extremes.
    run_phase(16'd3, 70, 1'b0);
    run_phase(16'd1, 90, 1'b0);
    run_phase(16'd2, 60, 1'b1);
    run_phase(16'hFFFF, 20, 1'b0);
    run_phase(16'd0, 20, 1'b0);

    $display("covered %0d commands and %0d results over %0d resolution writes",
             n_cmds, n_results, n_cfg);
    $display("results: %0d expirations, %0d table full, %0d id not found",
             n_fired, n_full, n_missing);
    if (fail_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mcst_pkg.sv
hw/rtl/mcst_ifs.sv
hw/rtl/mcst_ram.sv
hw/rtl/multi_channel_software_timer_table_core.sv
tb/tb.sv
